/* hdl/sensor_word_crc_check_convert_assert.svh */
// assertion macros for the sensor word checker
`ifndef SENSOR_WORD_CRC_CHECK_CONVERT_ASSERT_SVH
`define SENSOR_WORD_CRC_CHECK_CONVERT_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define SWCC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sensor word check failed: cond");

// consequence holds in the cycle after the trigger
`define SWCC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("sensor word check failed: trig then cons");

`else

`define SWCC_ASSERT(lbl, cond)
`define SWCC_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

/* hdl/swcc_pkg.sv */
package swcc_pkg;

  // crc-8 parameters
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // scaling of the word to hundredths
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [15:0] TEMP_BASE   = 16'd4500;
  localparam logic [16:0] WORD_MAX    = 17'd65535;

  // position of the next byte in its triple
  typedef enum logic [1:0] {
    POS_HIGH  = 2'd0,
    POS_LOW   = 2'd1,
    POS_CHECK = 2'd2
  } byte_pos_e;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/sensor_word_crc_check_convert.sv */
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   rx_byte_i, frame_start_i
// out      output     out_valid_o / out_stall_i word_value_o, crc_ok_o, computed_crc_o,
//                                               temp_centi_o, humidity_centi_o
//
// one byte is taken every cycle while in_valid_i is high and in_stall_o is low; only a check byte makes a result
// the edge that takes the check byte loads the word register; the result register loads
// on the next edge on which the block advances, which raises out_valid_o
// reset (rst_ni low, asynchronous) empties both registers and returns to the high byte
// in_stall_o is high exactly while a result waits at the output and out_stall_i is high
`include "sensor_word_crc_check_convert_assert.svh"

module sensor_word_crc_check_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        word_value_o,
  output logic               crc_ok_o,
  output logic [7:0]         computed_crc_o,
  output logic signed [14:0] temp_centi_o,
  output logic [13:0]        humidity_centi_o
);

  // pipeline advance
  logic advance;
  logic accept;

  // frame state
  swcc_pkg::byte_pos_e pos_q, pos_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic [7:0] crc_q, crc_d;
  logic       emit;

  // stage one: checked word
  logic        s1_valid_q;
  logic [15:0] s1_word_q;
  logic [7:0]  s1_crc_q;
  logic        s1_ok_q;

  // stage two: scaling, division by 65535 and offset
  logic        out_valid_q;
  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic [16:0] temp_sum;
  logic [16:0] hum_sum;
  logic [14:0] temp_quot;
  logic [13:0] hum_quot;
  logic [15:0] temp_wide;

  assign advance    = !(out_valid_q && out_stall_i);
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= swcc_pkg::POS_HIGH;
      high_q <= 8'd0;
      low_q  <= 8'd0;
      crc_q  <= swcc_pkg::CRC_INIT;
    end else if (accept) begin
      pos_q  <= pos_d;
      high_q <= high_d;
      low_q  <= low_d;
      crc_q  <= crc_d;
    end
  end

  // byte position decode and crc update
  always_comb begin
    swcc_pkg::byte_pos_e pos_eff;
    pos_eff = frame_start_i ? swcc_pkg::POS_HIGH : pos_q;
    pos_d   = pos_q;
    high_d  = high_q;
    low_d   = low_q;
    crc_d   = crc_q;
    emit    = 1'b0;
    unique case (pos_eff)
      swcc_pkg::POS_LOW: begin
        low_d = rx_byte_i;
        crc_d = swcc_pkg::crc8_update(crc_q, rx_byte_i);
        pos_d = swcc_pkg::POS_CHECK;
      end
      swcc_pkg::POS_CHECK: begin
        emit  = 1'b1;
        crc_d = swcc_pkg::CRC_INIT;
        pos_d = swcc_pkg::POS_HIGH;
      end
      default: begin
        high_d = rx_byte_i;
        crc_d  = swcc_pkg::crc8_update(swcc_pkg::CRC_INIT, rx_byte_i);
        pos_d  = swcc_pkg::POS_LOW;
      end
    endcase
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept && emit;
      out_valid_q <= s1_valid_q;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_word_q <= {high_q, low_q};
      s1_crc_q  <= crc_q;
      s1_ok_q   <= (rx_byte_i == crc_q);
    end
  end

  // floor(x / 65535) = hi + (hi + lo >= 65535), with hi = x >> 16, lo = x mod 65536
  always_comb begin
    temp_prod = 31'(s1_word_q) * 31'(swcc_pkg::TEMP_SCALE);
    hum_prod  = 30'(s1_word_q) * 30'(swcc_pkg::HUM_SCALE);
    temp_sum  = 17'(temp_prod[30:16]) + 17'(temp_prod[15:0]);
    hum_sum   = 17'(hum_prod[29:16]) + 17'(hum_prod[15:0]);
    temp_quot = temp_prod[30:16] + 15'(temp_sum >= swcc_pkg::WORD_MAX);
    hum_quot  = hum_prod[29:16] + 14'(hum_sum >= swcc_pkg::WORD_MAX);
    temp_wide = {1'b0, temp_quot} - swcc_pkg::TEMP_BASE;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_value_o     <= s1_word_q;
      crc_ok_o         <= s1_ok_q;
      computed_crc_o   <= s1_crc_q;
      temp_centi_o     <= signed'(temp_wide[14:0]);
      humidity_centi_o <= hum_quot;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks on the pipeline and the conversions
  `SWCC_ASSERT(a_pos_legal, pos_q != 2'd3)
  `SWCC_ASSERT_NEXT(a_stall_holds, out_valid_q && out_stall_i, out_valid_q && $stable(s1_valid_q))
  `SWCC_ASSERT_NEXT(a_check_emits, accept && !frame_start_i && pos_q == swcc_pkg::POS_CHECK, s1_valid_q)
  `SWCC_ASSERT(a_hum_range, !out_valid_q || humidity_centi_o <= 14'd10000)

endmodule

/* sim/sensor_word_crc_check_convert_test.sv */
`timescale 1ns / 1ps

module sensor_word_crc_check_convert_test;

  // one converted word as it leaves the block
  typedef struct {
    logic [15:0]        word;
    logic               crc_ok;
    logic [7:0]         crc;
    logic signed [14:0] temp;
    logic [13:0]        humidity;
  } sensor_word_t;

  // tracks the byte triples and holds the words still to come out
  class crc_word_scoreboard;
    sensor_word_t         expected_words[$];
    swcc_pkg::byte_pos_e  pos;
    logic [7:0]           high_byte;
    logic [7:0]           low_byte;
    logic [7:0]           crc;
    int                   errors;
    int                   bytes_taken;
    int                   words_checked;
    int                   bad_crc_words;

    function new();
      pos = swcc_pkg::POS_HIGH;
      high_byte = 8'h00;
      low_byte = 8'h00;
      crc = swcc_pkg::CRC_INIT;
    endfunction

    // crc-8, one input bit at a time, msb first
    static function logic [7:0] crc8_step(logic [7:0] c_in, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = c_in;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c = {c[6:0], 1'b0};
        if (fb) c = c ^ swcc_pkg::CRC_POLY;
      end
      return c;
    endfunction

    // one accepted input transfer
    function void note_byte(logic [7:0] b, logic fs);
      int unsigned  w;
      int unsigned  t;
      int unsigned  h;
      int           temp;
      sensor_word_t exp_word;
      bytes_taken++;
      if (fs) begin
        pos = swcc_pkg::POS_HIGH;
        crc = swcc_pkg::CRC_INIT;
      end
      case (pos)
        swcc_pkg::POS_LOW: begin
          low_byte = b;
          crc = crc8_step(crc, b);
          pos = swcc_pkg::POS_CHECK;
        end
        swcc_pkg::POS_CHECK: begin
          w = 32'({high_byte, low_byte});
          // floor scaling to hundredths of a degree and of a percent
          t = (w * 32'd17500) / 32'd65535;
          h = (w * 32'd10000) / 32'd65535;
          temp = int'(t) - 4500;
          exp_word.word = w[15:0];
          exp_word.crc_ok = (b == crc);
          exp_word.crc = crc;
          exp_word.temp = temp[14:0];
          exp_word.humidity = h[13:0];
          expected_words.push_back(exp_word);
          pos = swcc_pkg::POS_HIGH;
          crc = swcc_pkg::CRC_INIT;
        end
        default: begin
          high_byte = b;
          crc = crc8_step(swcc_pkg::CRC_INIT, b);
          pos = swcc_pkg::POS_LOW;
        end
      endcase
    endfunction

    // one accepted output transfer against the oldest expected word
    function void check_word(sensor_word_t got);
      sensor_word_t exp_word;
      if (expected_words.size() == 0) begin
        $error("unexpected word: word_value %0h", got.word);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      words_checked++;
      if (!exp_word.crc_ok) bad_crc_words++;
      if (got.word !== exp_word.word) begin
        $error("word_value: expected %0h, got %0h", exp_word.word, got.word);
        errors++;
      end
      if (got.crc_ok !== exp_word.crc_ok) begin
        $error("crc_ok: expected %0b, got %0b", exp_word.crc_ok, got.crc_ok);
        errors++;
      end
      if (got.crc !== exp_word.crc) begin
        $error("computed_crc: expected %0h, got %0h", exp_word.crc, got.crc);
        errors++;
      end
      if (got.temp !== exp_word.temp) begin
        $error("temp_centi: expected %0d, got %0d", exp_word.temp, got.temp);
        errors++;
      end
      if (got.humidity !== exp_word.humidity) begin
        $error("humidity_centi: expected %0d, got %0d", exp_word.humidity, got.humidity);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        word_value_o;
  logic               crc_ok_o;
  logic [7:0]         computed_crc_o;
  logic signed [14:0] temp_centi_o;
  logic [13:0]        humidity_centi_o;

  crc_word_scoreboard sb = new();
  int                 send_gap_pct = 18;
  int                 recv_stall_pct = 75;
  int                 sent_bytes;

  sensor_word_crc_check_convert dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_value_o    (word_value_o),
    .crc_ok_o        (crc_ok_o),
    .computed_crc_o  (computed_crc_o),
    .temp_centi_o    (temp_centi_o),
    .humidity_centi_o(humidity_centi_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    sensor_word_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(rx_byte_i, frame_start_i);
      if (out_valid_o && !out_stall_i) begin
        got.word = word_value_o;
        got.crc_ok = crc_ok_o;
        got.crc = computed_crc_o;
        got.temp = temp_centi_o;
        got.humidity = humidity_centi_o;
        sb.check_word(got);
      end
    end
  end

  // entered and left at a falling edge; valid stays high for a following byte
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  // high, low and check byte; a bad check byte has one bit flipped
  task automatic send_triple(input logic [7:0] hi, input logic [7:0] lo, input logic fs,
                             input bit bad);
    logic [7:0] chk;
    chk = crc_word_scoreboard::crc8_step(
            crc_word_scoreboard::crc8_step(swcc_pkg::CRC_INIT, hi), lo);
    if (bad) chk = chk ^ (8'h01 << $urandom_range(7));
    send_byte(hi, fs);
    send_byte(lo, 1'b0);
    send_byte(chk, 1'b0);
  endtask

  // hold off the sender until every expected word is out
  task automatic drain_words();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly whole frames, some stray bytes and cut-off triples
  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int n_triples;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      case ($urandom_range(9))
        0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        1: begin
          send_byte(data_byte(), 1'b1);
          if ($urandom_range(1)) send_byte(data_byte(), 1'b0);
        end
        default: begin
          n_triples = $urandom_range(1, 3);
          for (int k = 0; k < n_triples; k++) begin
            send_triple(data_byte(), data_byte(), k == 0, $urandom_range(4) == 0);
          end
        end
      endcase
    end
  endtask

  initial begin
    #5_000_000;
    $display("sensor_word_crc_check_convert_test: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, bad check byte, frame start mid-triple
    send_triple(8'h00, 8'h00, 1'b1, 1'b0);
    send_triple(8'hFF, 8'hFF, 1'b0, 1'b0);
    send_triple(8'h12, 8'h34, 1'b1, 1'b1);
    send_byte(8'hAB, 1'b1);
    send_triple(8'hCD, 8'hEF, 1'b1, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_triple(8'h33, 8'h44, 1'b1, 1'b0);
    send_triple(8'h80, 8'h01, 1'b0, 1'b0);
    send_triple(8'h7F, 8'hFE, 1'b1, 1'b1);
    drain_words();

    // busy sender, receiver mostly stalled
    random_traffic(500);
    drain_words();

    // the other way round
    send_gap_pct = 75;
    recv_stall_pct = 18;
    random_traffic(500);
    drain_words();

    // full rate both sides
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_traffic(500);
    drain_words();
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes (%0d taken), checked %0d words, %0d of them with a bad check byte",
             sent_bytes, sb.bytes_taken, sb.words_checked, sb.bad_crc_words);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sensor_word_crc_check_convert_test: done, clean");
    end else begin
      $display("sensor_word_crc_check_convert_test: done, errors");
    end
    $finish;
  end

endmodule

/* sensor_word_crc_check_convert.f */
+incdir+hdl
hdl/swcc_pkg.sv
hdl/sensor_word_crc_check_convert.sv
sim/sensor_word_crc_check_convert_test.sv
